// ===== rtl/hsl2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_pkg
// Shared types, constants and helper functions of the HSV/HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    // unit value of the Q0.16 inputs
    localparam logic [16:0] FX_ONE       = 17'd65536;
    // hue position: 65536 per sextant, six sextants per turn
    localparam logic [19:0] SIX_SEXTANTS = 20'd393216;
    localparam logic [18:0] TRAP_FALL    = 19'd196608;

    // sextant shift of each lane: index 0 red, 1 green, 2 blue
    localparam logic [2:0][18:0] LANE_SHIFT = {19'd262144, 19'd0, 19'd131072};

    // divider: 17 quotient bits, at most four of them per register stage
    localparam int QUO_W      = 17;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (QUO_W + DIV_STEPS - 1) / DIV_STEPS;

    // color on its way to the channel lanes
    typedef struct packed {
        logic        use_q;   // saturation comes from the divider
        logic [18:0] pos;     // hue position, 0..393210
        logic [16:0] sat;     // saturation, Q0.16
        logic [16:0] val;     // value, Q0.16
    } t_pix;

    // restoring divider state
    typedef struct packed {
        logic [33:0] rem;     // partial remainder, below the divisor unless that is zero
        logic [33:0] dvs;     // divisor 2V, Q0.32
        logic [16:0] numlo;   // dividend bits still to shift in
        logic [16:0] quo;     // quotient bits so far
    } t_div;

    // one restoring step: shift in one dividend bit, subtract if it fits
    function automatic t_div div_step(input t_div d);
        t_div        r;
        logic [34:0] trial;
        r     = d;
        trial = {d.rem, d.numlo[16]};
        if (trial >= {1'b0, d.dvs}) begin
            r.rem = 34'(trial - {1'b0, d.dvs});
            r.quo = {d.quo[15:0], 1'b1};
        end else begin
            r.rem = trial[33:0];
            r.quo = {d.quo[15:0], 1'b0};
        end
        r.numlo = {d.numlo[15:0], 1'b0};
        return r;
    endfunction

    // trapeze: min(1, x) - clamp(x - 3, 0, 1), x in sextants
    function automatic logic [16:0] trapeze(input logic [18:0] pos);
        logic [16:0] rise;
        logic [18:0] over;
        logic [16:0] fall;
        rise = (pos < 19'(FX_ONE)) ? pos[16:0] : FX_ONE;
        over = 19'(pos - TRAP_FALL);
        if (pos <= TRAP_FALL) begin
            fall = 17'd0;
        end else if (over > 19'(FX_ONE)) begin
            fall = FX_ONE;
        end else begin
            fall = over[16:0];
        end
        return 17'(rise - fall);
    endfunction

endpackage

// ===== rtl/hsl2rgb_hexcone.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_hexcone
// Input clamping, hue scaling and HSL to hexcone mapping (two stages).
// ----------------------------------------------------------------------------
module hsl2rgb_hexcone (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_action,
    input  logic [15:0]       i_hue_turn,
    input  logic [16:0]       i_saturation,
    input  logic [16:0]       i_level,
    output logic              o_valid,
    output hsl2rgb_pkg::t_pix o_pix,
    output hsl2rgb_pkg::t_div o_div,
    input  logic              i_stall
);
    import hsl2rgb_pkg::*;

    logic        en1, en2;
    logic        r_v1, r_v2;
    logic        r_action;
    logic [18:0] r_pos;
    logic [16:0] r_sat, r_lev;
    logic [32:0] r_chroma;
    t_pix        r_pix, n_pix;
    t_div        r_div, n_div;

    logic [16:0] sat_c, lev_c, lev_gap;
    logic [17:0] twice;
    logic [33:0] v2, lev_sh;
    logic [50:0] num;
    logic [34:0] v_rnd;
    logic        over, zero;

    // stage enables
    assign en2     = !r_v2 || !i_stall;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    // clamp, hue * 6 and chroma
    always_comb begin
        sat_c = (i_saturation > FX_ONE) ? FX_ONE : i_saturation;
        lev_c = (i_level > FX_ONE) ? FX_ONE : i_level;
        twice = {lev_c, 1'b0};
        if (twice >= 18'(FX_ONE)) begin
            lev_gap = 17'(twice - 18'(FX_ONE));
        end else begin
            lev_gap = 17'(18'(FX_ONE) - twice);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_action <= i_action;
            r_pos    <= 19'({i_hue_turn, 2'b00}) + 19'({i_hue_turn, 1'b0});
            r_sat    <= sat_c;
            r_lev    <= lev_c;
            r_chroma <= 33'({17'd0, 17'(FX_ONE - lev_gap)} * {17'd0, sat_c});
        end
    end

    // twice the hexcone value, dividend and HSL special cases
    always_comb begin
        lev_sh = {r_lev, 17'd0};
        v2     = 34'({1'b0, r_chroma}) + lev_sh;
        num    = 51'({r_chroma, 17'd0}) + 51'(v2[33:1]);
        v_rnd  = 35'(v2) + 35'd65536;
        zero   = (v2 == 34'd0);
        over   = ({1'b0, r_chroma} > lev_sh);

        n_pix.use_q = r_action && !zero && !over;
        n_pix.pos   = r_pos;
        n_pix.sat   = r_action ? 17'd0 : r_sat;
        n_pix.val   = r_action ? v_rnd[33:17] : r_lev;

        n_div.rem   = num[50:17];
        n_div.dvs   = v2;
        n_div.numlo = num[16:0];
        n_div.quo   = 17'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pix <= n_pix;
            r_div <= n_div;
        end
    end

    assign o_valid = r_v2;
    assign o_pix   = r_pix;
    assign o_div   = r_div;

endmodule

// ===== rtl/hsl2rgb_divider.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_divider
// Pipelined restoring divider for the HSL saturation C / V.
// ----------------------------------------------------------------------------
module hsl2rgb_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hsl2rgb_pkg::t_pix i_pix,
    input  hsl2rgb_pkg::t_div i_div,
    output logic              o_valid,
    output hsl2rgb_pkg::t_pix o_pix,
    input  logic              i_stall
);
    import hsl2rgb_pkg::*;

    logic r_v   [DIV_STAGES];
    logic en    [DIV_STAGES];
    t_pix r_pix [DIV_STAGES];
    t_div r_div [DIV_STAGES];
    t_div n_div [DIV_STAGES];

    // stage enables, from the output backward
    always_comb begin
        en[DIV_STAGES-1] = !r_v[DIV_STAGES-1] || !i_stall;
        for (int k = DIV_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        t_div d_in;
        t_pix p_in;
        logic v_in;

        // stage input
        if (s == 0) begin : g_first
            assign d_in = i_div;
            assign p_in = i_pix;
            assign v_in = i_valid;
        end else begin : g_next
            assign d_in = r_div[s-1];
            assign p_in = r_pix[s-1];
            assign v_in = r_v[s-1];
        end

        // quotient bits of this stage
        always_comb begin
            t_div d;
            d = d_in;
            for (int j = 0; j < DIV_STEPS; j++) begin
                if (s * DIV_STEPS + j < QUO_W) begin
                    d = div_step(d);
                end
            end
            n_div[s] = d;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (en[s]) begin
                r_v[s] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[s]) begin
                r_div[s] <= n_div[s];
                r_pix[s] <= p_in;
            end
        end
    end

    // resolve the saturation source
    always_comb begin
        o_pix       = r_pix[DIV_STAGES-1];
        o_pix.use_q = 1'b0;
        if (r_pix[DIV_STAGES-1].use_q) begin
            o_pix.sat = r_div[DIV_STAGES-1].quo;
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];

endmodule

// ===== rtl/hsl2rgb_lanes.sv =====
// ----------------------------------------------------------------------------
// hsl2rgb_lanes
// Trapeze, blend and scaling of the red, green and blue lanes (three stages).
// ----------------------------------------------------------------------------
module hsl2rgb_lanes (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  hsl2rgb_pkg::t_pix i_pix,
    output logic              o_valid,
    output logic [2:0][15:0]  o_rgb,
    input  logic              i_stall
);
    import hsl2rgb_pkg::*;

    logic             ena, enb, enc;
    logic             r_va, r_vb, r_vc;
    logic [16:0]      r_val;
    logic [2:0][32:0] r_inner, n_inner;
    logic [2:0][48:0] r_prod, n_prod;
    logic [2:0][15:0] r_rgb, n_rgb;

    // stage enables
    assign enc     = !r_vc || !i_stall;
    assign enb     = !r_vb || enc;
    assign ena     = !r_va || enb;
    assign o_stall = !ena;

    // shifted hue, trapeze and (1 - S) + S * t per lane
    always_comb begin
        logic [19:0] p;
        logic [16:0] t;
        for (int l = 0; l < 3; l++) begin
            p = {1'b0, i_pix.pos} + {1'b0, LANE_SHIFT[l]};
            if (p >= SIX_SEXTANTS) begin
                p = 20'(p - SIX_SEXTANTS);
            end
            t = trapeze(p[18:0]);
            n_inner[l] = 33'(({17'd0, 17'(FX_ONE - i_pix.sat)} << 16)
                             + ({17'd0, i_pix.sat} * {17'd0, t}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (ena) begin
                r_va <= i_valid;
            end
            if (enb) begin
                r_vb <= r_va;
            end
            if (enc) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ena) begin
            r_inner <= n_inner;
            r_val   <= i_pix.val;
        end
    end

    // value times blend
    always_comb begin
        logic [49:0] m;
        for (int l = 0; l < 3; l++) begin
            m         = {33'd0, r_val} * {17'd0, r_inner[l]};
            n_prod[l] = m[48:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (enb) begin
            r_prod <= n_prod;
        end
    end

    // scale by 65535 and round half up
    always_comb begin
        logic [65:0] x;
        for (int l = 0; l < 3; l++) begin
            x = {1'b0, r_prod[l], 16'd0} - {17'd0, r_prod[l]}
                + 66'h0_0000_8000_0000_0000;
            n_rgb[l] = x[63:48];
        end
    end

    always_ff @(posedge i_clk) begin
        if (enc) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_valid = r_vc;
    assign o_rgb   = r_rgb;

endmodule

// ===== rtl/hsl2rgb_hsv_to_rgb_convert_unit.sv =====
// ----------------------------------------------------------------------------
// hsl_hsv_to_rgb_convert_unit
// HSV / HSL to 16-bit RGB color converter, fully pipelined.
// ----------------------------------------------------------------------------
// The input channel (i_valid / o_stall) takes one color per transfer: mode
// (0 HSV, 1 HSL), hue as a fraction of a turn, saturation and value or
// luminosity in Q0.16 (values above 1.0 are clamped). The output channel
// (o_valid / i_stall) delivers the rounded red, green and blue channels.
// Colors pass the clamping and hexcone mapping stages, then the 17-bit
// restoring divider that forms the HSL saturation (at most four quotient
// bits per stage), then the trapeze, blend and 65535 scaling stages.
// Throughput is one color per cycle when not stalled; HSV items pass
// through the divider stages as well, so every item takes the same path.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles are squeezed out and a new color is
// taken even while a finished result waits at the output.
// When the receiver stalls, results stay in the output register unchanged
// and o_stall rises only once every stage holds a color.
// Reset clears all valid bits; the pipeline is empty afterwards.
// ----------------------------------------------------------------------------
module hsl_hsv_to_rgb_convert_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [15:0] i_hue_turn,
    input  logic [16:0] i_saturation,
    input  logic [16:0] i_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out
);
    import hsl2rgb_pkg::*;

    logic             cone_valid, cone_stall;
    t_pix             cone_pix;
    t_div             cone_div;
    logic             div_valid, div_stall;
    t_pix             div_pix;
    logic [2:0][15:0] rgb;

    // clamping and hexcone mapping
    hsl2rgb_hexcone u_hexcone (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_hue_turn   (i_hue_turn),
        .i_saturation (i_saturation),
        .i_level      (i_level),
        .o_valid      (cone_valid),
        .o_pix        (cone_pix),
        .o_div        (cone_div),
        .i_stall      (cone_stall)
    );

    // HSL saturation divider
    hsl2rgb_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cone_valid),
        .o_stall (cone_stall),
        .i_pix   (cone_pix),
        .i_div   (cone_div),
        .o_valid (div_valid),
        .o_pix   (div_pix),
        .i_stall (div_stall)
    );

    // per-channel trapeze and scaling
    hsl2rgb_lanes u_lanes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_stall (div_stall),
        .i_pix   (div_pix),
        .o_valid (o_valid),
        .o_rgb   (rgb),
        .i_stall (i_stall)
    );

    assign o_red_out   = rgb[0];
    assign o_green_out = rgb[1];
    assign o_blue_out  = rgb[2];

endmodule

// ===== sim/hsl_hsv_to_rgb_convert_unit_tb.sv =====
// ----------------------------------------------------------------------------
// hsl_hsv_to_rgb_convert_unit_tb
// Drives HSV and HSL colors into the converter and compares each RGB result
// against a fixed-point prediction kept in order in a scoreboard. Runs a
// directed set of corner colors, then random colors under several patterns
// of sender gaps and receiver stalls, including a long receiver hold-off.
// ----------------------------------------------------------------------------
module hsl_hsv_to_rgb_convert_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit MODE_HSV = 1'b0;
    localparam bit MODE_HSL = 1'b1;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb;

    // expected colors in transfer order, plus the fixed-point predictor
    class colour_board;
        localparam longint unsigned UNIT = 65536;
        localparam longint unsigned TURN = 6 * 65536;

        t_rgb expected_rgb[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction

        // min(1, x) - clamp(x - 3, 0, 1), x in sextants
        function longint unsigned trapeze_level(longint unsigned p);
            longint unsigned rise;
            longint unsigned fall;
            rise = (p < UNIT) ? p : UNIT;
            fall = 0;
            if (p > 3 * UNIT) begin
                fall = p - 3 * UNIT;
                if (fall > UNIT) fall = UNIT;
            end
            return rise - fall;
        endfunction

        // value * ((1 - S) + S * trapeze), rounded to 16 bits
        function logic [15:0] lane_level(longint unsigned p, longint unsigned sat,
                                         longint unsigned val);
            longint unsigned t;
            longint unsigned inner;
            longint unsigned num;
            t     = trapeze_level(p % TURN);
            inner = (UNIT - sat) * UNIT + sat * t;
            num   = val * inner * 65535 + (64'd1 << 47);
            return 16'(num >> 48);
        endfunction

        function t_rgb predict_rgb(bit mode, logic [15:0] hue, logic [16:0] sat_in,
                                   logic [16:0] lev_in);
            longint unsigned sat;
            longint unsigned lev;
            longint unsigned dbl;
            longint unsigned gap;
            longint unsigned chroma;
            longint unsigned twice_v;
            longint unsigned p;
            t_rgb            res;
            sat = (64'(sat_in) > UNIT) ? UNIT : 64'(sat_in);
            lev = (64'(lev_in) > UNIT) ? UNIT : 64'(lev_in);
            // hsl onto the hexcone
            if (mode == MODE_HSL) begin
                dbl     = 2 * lev;
                gap     = (dbl >= UNIT) ? dbl - UNIT : UNIT - dbl;
                chroma  = (UNIT - gap) * sat;
                twice_v = chroma + (lev << 17);
                if (twice_v == 0 || 2 * chroma > twice_v) begin
                    sat = 0;
                end else begin
                    sat = ((chroma << 17) + twice_v / 2) / twice_v;
                end
                lev = (twice_v + (64'd1 << 16)) >> 17;
            end
            p         = 64'(hue) * 6;
            res.red   = lane_level(p + 2 * UNIT, sat, lev);
            res.green = lane_level(p, sat, lev);
            res.blue  = lane_level(p + 4 * UNIT, sat, lev);
            return res;
        endfunction

        function void note_colour(bit mode, logic [15:0] hue, logic [16:0] sat,
                                  logic [16:0] lev);
            expected_rgb.push_back(predict_rgb(mode, hue, sat, lev));
        endfunction

        function void check_rgb(logic [15:0] r, logic [15:0] g, logic [15:0] b);
            t_rgb want;
            if (expected_rgb.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: %0d %0d %0d", r, g, b);
                return;
            end
            want = expected_rgb.pop_front();
            if (r !== want.red || g !== want.green || b !== want.blue) begin
                errors++;
                if (errors <= 10)
                    $display("rgb mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                             want.red, want.green, want.blue, r, g, b);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_action;
    logic [15:0] i_hue_turn;
    logic [16:0] i_saturation;
    logic [16:0] i_level;
    logic        o_valid;
    logic        i_stall;
    logic [15:0] o_red_out;
    logic [15:0] o_green_out;
    logic [15:0] o_blue_out;

    colour_board board;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          hold_left;

    hsl_hsv_to_rgb_convert_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_hue_turn   (i_hue_turn),
        .i_saturation (i_saturation),
        .i_level      (i_level),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // input and output transfer monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            board.note_colour(i_action, i_hue_turn, i_saturation, i_level);
        if (i_rst_n && o_valid && !i_stall)
            board.check_rgb(o_red_out, o_green_out, o_blue_out);
    end

    // one input transfer, then a random gap
    task automatic offer_colour(bit mode, logic [15:0] hue, logic [16:0] sat,
                                logic [16:0] lev);
        i_valid      <= 1'b1;
        i_action     <= mode;
        i_hue_turn   <= hue;
        i_saturation <= sat;
        i_level      <= lev;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // saturation or level, biased toward the corners and the clamp
    function automatic logic [16:0] pick_fraction();
        case ($urandom_range(9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(131071, 65537));
            3: return 17'($urandom_range(32769, 32767));
            4: return 17'($urandom_range(3));
            5: return 17'($urandom_range(131071));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    // hue, sometimes at or next to a sextant boundary
    function automatic logic [15:0] pick_hue();
        int h;
        if ($urandom_range(3) == 0) begin
            h = ($urandom_range(5) * 65536) / 6 + $urandom_range(2) - 1;
            return 16'(h);
        end
        return 16'($urandom_range(65535));
    endfunction

    task automatic offer_random(int count);
        for (int k = 0; k < count; k++)
            offer_colour(bit'($urandom_range(1)), pick_hue(), pick_fraction(),
                         pick_fraction());
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        offer_random(count);
        wait_drained();
    endtask

    // corner colors in both modes
    task automatic offer_corners();
        offer_colour(MODE_HSV, 16'd0,     17'd65536,  17'd65536);
        offer_colour(MODE_HSV, 16'd65535, 17'd65536,  17'd65536);
        offer_colour(MODE_HSV, 16'd10922, 17'd0,      17'd65536);
        offer_colour(MODE_HSV, 16'd10923, 17'd65536,  17'd0);
        offer_colour(MODE_HSV, 16'd21845, 17'd131071, 17'd131071);
        offer_colour(MODE_HSV, 16'd32768, 17'd65537,  17'd32768);
        offer_colour(MODE_HSV, 16'd43690, 17'd1,      17'd1);
        offer_colour(MODE_HSV, 16'd54613, 17'd65535,  17'd65535);
        offer_colour(MODE_HSV, 16'd54614, 17'd32768,  17'd98304);
        // hsl: zero luminosity gives zero value
        offer_colour(MODE_HSL, 16'd0,     17'd65536,  17'd0);
        offer_colour(MODE_HSL, 16'd12345, 17'd0,      17'd0);
        offer_colour(MODE_HSL, 16'd0,     17'd65536,  17'd32768);
        offer_colour(MODE_HSL, 16'd65535, 17'd65536,  17'd65536);
        offer_colour(MODE_HSL, 16'd21846, 17'd131071, 17'd131071);
        offer_colour(MODE_HSL, 16'd43691, 17'd65536,  17'd1);
        offer_colour(MODE_HSL, 16'd32767, 17'd65535,  17'd65535);
        offer_colour(MODE_HSL, 16'd10923, 17'd32768,  17'd32767);
        offer_colour(MODE_HSL, 16'd5000,  17'd0,      17'd65536);
        offer_colour(MODE_HSL, 16'd60000, 17'd100000, 17'd16384);
        offer_colour(MODE_HSL, 16'd30000, 17'd1,      17'd49152);
    endtask

    // main sequence
    initial begin
        board              = new();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left          <= 0;
        i_rst_n            <= 1'b0;
        i_valid            <= 1'b0;
        i_stall            <= 1'b0;
        i_action           <= MODE_HSV;
        i_hue_turn         <= 16'd0;
        i_saturation       <= 17'd0;
        i_level            <= 17'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer_corners();
        wait_drained();
        run_phase(150, 0, 0);
        run_phase(110, 73, 0);
        run_phase(110, 0, 73);
        run_phase(110, 37, 37);

        // long receiver hold-off while the sender keeps offering
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_left <= 80;
        offer_random(50);
        wait_drained();

        repeat (30) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("[hsl_hsv_to_rgb_convert_unit] OK");
        end else begin
            $display("[hsl_hsv_to_rgb_convert_unit] ERROR");
        end
        $finish;
    end

    // timeout
    initial begin
        #3_000_000;
        $display("[hsl_hsv_to_rgb_convert_unit] ERROR");
        $finish;
    end

endmodule
